// ===== rtl/core/breakpoint_fade_envelope_assert.svh =====
// assertion macros shared by the fade envelope modules
`ifndef BREAKPOINT_FADE_ENVELOPE_ASSERT_SVH
`define BREAKPOINT_FADE_ENVELOPE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BFE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfe check failed");

// next-cycle implication, checked out of reset
`define BFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfe check failed");

`endif

// ===== rtl/core/bfe_pkg.sv =====
// shared constants, types and helpers of the fade envelope
package bfe_pkg;

  localparam int MAX_POINTS     = 16;
  localparam int IDX_W          = $clog2(MAX_POINTS);
  localparam int CNT_W          = $clog2(MAX_POINTS + 1);
  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int GAIN_W         = 16;
  localparam int CLK_W          = 32;
  localparam int OP_W           = 3;
  localparam int MUL_A_W        = CLK_W + 1;
  localparam int MUL_B_W        = GAIN_W + 1;
  localparam int PROD_W         = MUL_A_W + MUL_B_W;
  localparam int DIVD_W         = GAIN_W + CLK_W;

  localparam logic [GAIN_W-1:0] UNITY_GAIN =
    (GAIN_FRAC_BITS < GAIN_W) ? GAIN_W'(64'd1 << GAIN_FRAC_BITS) : {GAIN_W{1'b1}};

  localparam logic signed [PROD_W-1:0] SMP_MAX =
    PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PROD_W-1:0] SMP_MIN = -SMP_MAX - PROD_W'(1);

  // input operation codes
  localparam logic [OP_W-1:0] OP_FRAME     = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_CLOCK = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD       = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
  localparam logic [OP_W-1:0] OP_FADE      = 3'd4;

  // point table commands
  localparam logic [1:0] TBL_NOP      = 2'd0;
  localparam logic [1:0] TBL_SET_GAIN = 2'd1;
  localparam logic [1:0] TBL_INSERT   = 2'd2;
  localparam logic [1:0] TBL_DELETE   = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [IDX_W-1:0]  idx;
    logic [CLK_W-1:0]  clk;
    logic [GAIN_W-1:0] gain;
  } tbl_cmd_t;

  // floor shift by the gain fraction, then clamp to the sample range
  function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    q = p >>> GAIN_FRAC_BITS;
    if (q > SMP_MAX) begin
      q = SMP_MAX;
    end else if (q < SMP_MIN) begin
      q = SMP_MIN;
    end
    return q[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/bfe_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module bfe_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bfe_pkg::DIVD_W-1:0] dividend,
  input  logic [bfe_pkg::CLK_W-1:0]  divisor,
  output logic                       busy,
  output logic                       done,
  output logic [bfe_pkg::GAIN_W-1:0] quotient
);
  import bfe_pkg::*;

  `include "breakpoint_fade_envelope_assert.svh"

  localparam int STEP_W = $clog2(GAIN_W + 1);

  logic [CLK_W-1:0]  rem;
  logic [GAIN_W-1:0] lo;
  logic [STEP_W-1:0] steps;
  logic [CLK_W:0]    trial;
  logic              ge;

  // high part of the dividend is known to be below the divisor
  assign trial = {rem, lo[GAIN_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= dividend[DIVD_W-1:GAIN_W];
        lo    <= dividend[GAIN_W-1:0];
        steps <= STEP_W'(GAIN_W);
      end else if (steps != '0) begin
        rem   <= ge ? CLK_W'(trial - {1'b0, divisor}) : trial[CLK_W-1:0];
        lo    <= {lo[GAIN_W-2:0], ge};
        steps <= steps - STEP_W'(1);
        done  <= (steps == STEP_W'(1));
      end
    end
  end

  assign busy     = (steps != '0);
  assign quotient = lo;

  `BFE_ASSERT_NOW(a_no_restart, start, !busy)
  `BFE_ASSERT_NEXT(a_start_runs, start, busy)
  `BFE_ASSERT_NOW(a_done_ends, done, !busy)

endmodule

// ===== rtl/core/bfe_table.sv =====
// sorted point table: a row of entries with insert, delete and gain rewrite
module bfe_table (
  input  logic                       clk,
  input  logic                       rst,
  input  bfe_pkg::tbl_cmd_t          cmd,
  input  logic [bfe_pkg::IDX_W-1:0]  rd_idx,
  output logic [bfe_pkg::CLK_W-1:0]  rd_clk,
  output logic [bfe_pkg::GAIN_W-1:0] rd_gain,
  output logic [bfe_pkg::CNT_W-1:0]  count
);
  import bfe_pkg::*;

  `include "breakpoint_fade_envelope_assert.svh"

  logic [CLK_W-1:0]  clocks [MAX_POINTS];
  logic [GAIN_W-1:0] gains  [MAX_POINTS];

  assign rd_clk  = clocks[rd_idx];
  assign rd_gain = gains[rd_idx];

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_POINTS; j++) begin
      case (cmd.op)
        TBL_SET_GAIN: begin
          if (IDX_W'(j) == cmd.idx) begin
            gains[j] <= cmd.gain;
          end
        end
        TBL_INSERT: begin
          if (IDX_W'(j) == cmd.idx) begin
            clocks[j] <= cmd.clk;
            gains[j]  <= cmd.gain;
          end else if (j > 0 && IDX_W'(j) > cmd.idx) begin
            clocks[j] <= clocks[(j > 0) ? j - 1 : 0];
            gains[j]  <= gains[(j > 0) ? j - 1 : 0];
          end
        end
        TBL_DELETE: begin
          if (j < MAX_POINTS - 1 && IDX_W'(j) >= cmd.idx) begin
            clocks[j] <= clocks[(j < MAX_POINTS - 1) ? j + 1 : j];
            gains[j]  <= gains[(j < MAX_POINTS - 1) ? j + 1 : j];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.op)
        TBL_INSERT: count <= count + CNT_W'(1);
        TBL_DELETE: count <= count - CNT_W'(1);
        default:    count <= count;
      endcase
    end
  end

  `BFE_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_POINTS))
  `BFE_ASSERT_NOW(a_insert_room, cmd.op == TBL_INSERT, count < CNT_W'(MAX_POINTS))
  `BFE_ASSERT_NOW(a_delete_some, cmd.op == TBL_DELETE, count != '0)

endmodule

// ===== rtl/core/breakpoint_fade_envelope.sv =====
// Breakpoint fade envelope: a table of up to 16 gain points sorted by frame clock,
// edited by set-clock, add, remove-range and fade-to words, and a frame word that
// interpolates the gain and scales a stereo sample pair. One word is taken at a time;
// the input stalls until its work is finished. An add scans the table one entry a cycle
// and then inserts or rewrites; a remove-range steps over each kept or deleted entry
// and ends with an end check; fade-to is a remove plus two adds. A frame scans the
// table entries, then inside a segment runs the multiply, starts the bit-serial
// divider and waits for it, deletes each pruned point, and runs the two sample
// multiplies and the output load. A frame result sits in an output register, so the
// next word can be taken while it waits.
module breakpoint_fade_envelope (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bfe_pkg::OP_W-1:0]        op,
  input  logic [bfe_pkg::CLK_W-1:0]       clock_req,
  input  logic [bfe_pkg::CLK_W-1:0]       end_clock,
  input  logic [bfe_pkg::GAIN_W-1:0]      gain_value,
  input  logic signed [bfe_pkg::SAMPLE_BITS-1:0] left_sample,
  input  logic signed [bfe_pkg::SAMPLE_BITS-1:0] right_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [bfe_pkg::SAMPLE_BITS-1:0] left_out,
  output logic signed [bfe_pkg::SAMPLE_BITS-1:0] right_out,
  output logic [bfe_pkg::GAIN_W-1:0]      applied_gain,
  output logic                            table_full
);
  import bfe_pkg::*;

  `include "breakpoint_fade_envelope_assert.svh"

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD_SCAN = 4'd1;
  localparam logic [3:0] S_ADD_INS  = 4'd2;
  localparam logic [3:0] S_RM_SCAN  = 4'd3;
  localparam logic [3:0] S_FR_SCAN  = 4'd4;
  localparam logic [3:0] S_FR_MUL   = 4'd5;
  localparam logic [3:0] S_FR_DSTRT = 4'd6;
  localparam logic [3:0] S_FR_DIV   = 4'd7;
  localparam logic [3:0] S_FR_PRUNE = 4'd8;
  localparam logic [3:0] S_FR_LEFT  = 4'd9;
  localparam logic [3:0] S_FR_RIGHT = 4'd10;
  localparam logic [3:0] S_FR_OUT   = 4'd11;

  localparam logic [1:0] FADE_NONE = 2'd0;
  localparam logic [1:0] FADE_NOW  = 2'd1;
  localparam logic [1:0] FADE_TGT  = 2'd2;

  logic [3:0]        state;
  logic [1:0]        fade_step;
  logic [CNT_W-1:0]  scan;
  logic [CNT_W-1:0]  pos;
  logic              hit;
  logic [CNT_W-1:0]  drop;
  logic [CLK_W-1:0]  key;
  logic [GAIN_W-1:0] key_gain;
  logic [CLK_W-1:0]  rm_lo;
  logic [CLK_W-1:0]  rm_hi;
  logic [CLK_W-1:0]  tgt_clk;
  logic [GAIN_W-1:0] tgt_gain;
  logic [CLK_W-1:0]  frame_clock;
  logic [GAIN_W-1:0] current_gain;
  logic              overflow;
  logic [GAIN_W-1:0] g0;
  logic [GAIN_W-1:0] gain;
  logic [GAIN_W-1:0] diff;
  logic              down;
  logic [CLK_W-1:0]  num;
  logic [CLK_W-1:0]  den;
  logic signed [SAMPLE_BITS-1:0] samp_l;
  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic signed [SAMPLE_BITS-1:0] left_res;
  logic signed [PROD_W-1:0]  prod;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  tbl_cmd_t          cmd;
  logic [CLK_W-1:0]  rd_clk;
  logic [GAIN_W-1:0] rd_gain;
  logic [CNT_W-1:0]  count;
  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [GAIN_W-1:0] div_q;
  logic              accept;
  logic              scan_end;

  bfe_table u_table (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_idx  (scan[IDX_W-1:0]),
    .rd_clk  (rd_clk),
    .rd_gain (rd_gain),
    .count   (count)
  );

  bfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[DIVD_W-1:0]),
    .divisor  (den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign div_start = (state == S_FR_DSTRT);
  assign scan_end  = (scan == count);

  // one shared signed multiplier: interpolation step and sample scaling
  always_comb begin
    mul_a = {1'b0, num};
    mul_b = {1'b0, diff};
    if (state == S_FR_LEFT) begin
      mul_a = {{(MUL_A_W - SAMPLE_BITS){samp_l[SAMPLE_BITS-1]}}, samp_l};
      mul_b = {1'b0, gain};
    end else if (state == S_FR_RIGHT) begin
      mul_a = {{(MUL_A_W - SAMPLE_BITS){samp_r[SAMPLE_BITS-1]}}, samp_r};
      mul_b = {1'b0, gain};
    end
  end
  assign mul_p = mul_a * mul_b;

  // table commands come straight from the sequencer state
  always_comb begin
    cmd.op   = TBL_NOP;
    cmd.idx  = scan[IDX_W-1:0];
    cmd.clk  = key;
    cmd.gain = key_gain;
    case (state)
      S_ADD_SCAN: begin
        if (!scan_end && rd_clk == key) begin
          cmd.op = TBL_SET_GAIN;
        end
      end
      S_ADD_INS: begin
        cmd.idx = pos[IDX_W-1:0];
        if (!hit && count < CNT_W'(MAX_POINTS)) begin
          cmd.op = TBL_INSERT;
        end
      end
      S_RM_SCAN: begin
        if (!scan_end && rd_clk >= rm_lo && rd_clk < rm_hi) begin
          cmd.op = TBL_DELETE;
        end
      end
      S_FR_PRUNE: begin
        cmd.idx = '0;
        if (drop != '0) begin
          cmd.op = TBL_DELETE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fade_step    <= FADE_NONE;
      frame_clock  <= '0;
      current_gain <= UNITY_GAIN;
      overflow     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FR_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            samp_l <= left_sample;
            samp_r <= right_sample;
            scan   <= '0;
            case (op)
              OP_FRAME: state <= S_FR_SCAN;
              OP_SET_CLOCK: frame_clock <= clock_req;
              OP_ADD: begin
                key      <= clock_req;
                key_gain <= gain_value;
                state    <= S_ADD_SCAN;
              end
              OP_REMOVE: begin
                rm_lo <= clock_req;
                rm_hi <= end_clock;
                state <= S_RM_SCAN;
              end
              OP_FADE: begin
                rm_lo     <= frame_clock;
                rm_hi     <= clock_req;
                tgt_clk   <= clock_req;
                tgt_gain  <= gain_value;
                fade_step <= FADE_NOW;
                state     <= S_RM_SCAN;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ADD_SCAN: begin
          if (scan_end || key < rd_clk) begin
            pos   <= scan;
            hit   <= 1'b0;
            state <= S_ADD_INS;
          end else if (rd_clk == key) begin
            pos   <= scan;
            hit   <= 1'b1;
            state <= S_ADD_INS;
          end else begin
            scan <= scan + CNT_W'(1);
          end
        end
        S_ADD_INS: begin
          // an equal-clock rewrite already happened during the scan
          if (!hit && count >= CNT_W'(MAX_POINTS)) begin
            overflow <= 1'b1;
          end
          scan <= '0;
          if (fade_step == FADE_TGT) begin
            key       <= tgt_clk;
            key_gain  <= tgt_gain;
            fade_step <= FADE_NONE;
            state     <= S_ADD_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RM_SCAN: begin
          if (scan_end) begin
            scan <= '0;
            if (fade_step == FADE_NOW) begin
              key       <= frame_clock;
              key_gain  <= current_gain;
              fade_step <= FADE_TGT;
              state     <= S_ADD_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end else if (cmd.op != TBL_DELETE) begin
            scan <= scan + CNT_W'(1);
          end
        end
        S_FR_SCAN: begin
          if (!scan_end && rd_clk <= frame_clock) begin
            g0   <= rd_gain;
            num  <= frame_clock - rd_clk;
            den  <= rd_clk;
            scan <= scan + CNT_W'(1);
          end else if (scan == '0) begin
            gain  <= current_gain;
            state <= S_FR_LEFT;
          end else begin
            drop <= (scan >= CNT_W'(2)) ? scan - CNT_W'(2) : '0;
            if (scan_end) begin
              gain         <= g0;
              current_gain <= g0;
              state        <= S_FR_PRUNE;
            end else begin
              // den held c0 so far; turn it into the segment length
              den   <= rd_clk - den;
              diff  <= (rd_gain >= g0) ? rd_gain - g0 : g0 - rd_gain;
              down  <= rd_gain < g0;
              state <= S_FR_MUL;
            end
          end
        end
        S_FR_MUL: begin
          prod <= mul_p;
          if (den == '0) begin
            gain         <= g0;
            current_gain <= g0;
            state        <= S_FR_PRUNE;
          end else begin
            state <= S_FR_DSTRT;
          end
        end
        S_FR_DSTRT: state <= S_FR_DIV;
        S_FR_DIV: begin
          if (div_done) begin
            gain         <= down ? g0 - div_q : g0 + div_q;
            current_gain <= down ? g0 - div_q : g0 + div_q;
            state        <= S_FR_PRUNE;
          end
        end
        S_FR_PRUNE: begin
          if (drop == '0) begin
            state <= S_FR_LEFT;
          end else begin
            drop <= drop - CNT_W'(1);
          end
        end
        S_FR_LEFT: begin
          prod  <= mul_p;
          state <= S_FR_RIGHT;
        end
        S_FR_RIGHT: begin
          left_res <= sat_sample(prod);
          prod     <= mul_p;
          state    <= S_FR_OUT;
        end
        S_FR_OUT: begin
          if (!out_valid || !out_stall) begin
            left_out     <= left_res;
            right_out    <= sat_sample(prod);
            applied_gain <= gain;
            table_full   <= overflow;
            overflow     <= 1'b0;
            frame_clock  <= frame_clock + CLK_W'(1);
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BFE_ASSERT_NOW(a_div_owner, div_done, state == S_FR_DIV)
  `BFE_ASSERT_NOW(a_div_idle_wait, state == S_FR_DIV && !div_busy, div_done)
  `BFE_ASSERT_NEXT(a_fade_leaves_idle, accept && op == OP_FADE, state == S_RM_SCAN)

endmodule
